### rtl/core/bvm_pkg.sv
// ---------------------------------------------------------------------------
// bvm_pkg - battery voltage monitor shared definitions
// Field widths, register indexes, reset values, microcode format and program.
// ---------------------------------------------------------------------------
package bvm_pkg;

	// ADC resolution; the sample and average fields stay 12 bits wide
	localparam int ADC_BITS   = 12;

	localparam int SAMPLE_W   = 12;
	localparam int AVG_W      = 12;
	localparam int MV_W       = 13;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 8;
	localparam int INTERVAL_W = 8;
	localparam int WEIGHT_W   = 4;
	localparam int VREF_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Low ADC_BITS bits of a 12-bit code
	localparam logic [AVG_W-1:0] AMASK =
		(ADC_BITS >= AVG_W) ? {AVG_W{1'b1}} : AVG_W'((1 << ADC_BITS) - 1);

	// Divider: numerator avg*w + sample, divisor w + 1, two quotient bits a step
	localparam int NUM_W     = AVG_W + WEIGHT_W;
	localparam int DVSR_W    = WEIGHT_W + 1;
	localparam int DIV_STEPS = NUM_W / 2;
	localparam int ITER_W    = $clog2(DIV_STEPS);

	// Scaling: 2 * vref * avg
	localparam int PROD_W    = VREF_W + AVG_W + 1;

	localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

	// Reset values
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 8'd20;
	localparam logic [WEIGHT_W-1:0]   RST_WEIGHT   = 4'd10;
	localparam logic [VREF_W-1:0]     RST_VREF     = 12'd2990;
	localparam logic [MV_W-1:0]       RST_LOW      = 13'd3400;
	localparam logic [MV_W-1:0]       RST_CRIT     = 13'd3200;
	localparam logic [MV_W-1:0]       RST_ABSENT   = 13'd500;
	localparam logic [COUNT_W-1:0]    RST_LIMIT    = 8'd5;
	localparam logic [AVG_W-1:0]      RST_AVG      = 12'd2525;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL = 3'd0,
		REG_WEIGHT   = 3'd1,
		REG_VREF     = 3'd2,
		REG_LOW      = 3'd3,
		REG_CRIT     = 3'd4,
		REG_ABSENT   = 3'd5,
		REG_LIMIT    = 3'd6
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		BAT_NORMAL     = 2'd0,
		BAT_LOW        = 2'd1,
		BAT_DISCHARGED = 2'd2,
		BAT_ABSENT     = 2'd3
	} bat_status_t;

	// Microcode
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_WAIT,   // take a tick, load the divider on a measuring tick
		OP_DIV,    // two quotient bits
		OP_MUL,    // latch average, multiply by vref
		OP_SCALE,  // shift down and saturate
		OP_CLASS   // count, latch, classify, load result
	} op_t;

	typedef enum logic [1:0] {
		JMP_NEVER,
		JMP_NO_START,
		JMP_DIV_BUSY,
		JMP_OUT_BUSY
	} jmp_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		step_t target;
		logic  last;
	} ctrl_t;

	typedef struct packed {
		logic start;     // measuring tick accepted
		logic div_busy;  // divider not on its final step
		logic out_busy;  // result register still held
	} cond_t;

	localparam step_t STEP_WAIT  = 3'd0;
	localparam step_t STEP_DIV   = 3'd1;
	localparam step_t STEP_MUL   = 3'd2;
	localparam step_t STEP_SCALE = 3'd3;
	localparam step_t STEP_CLASS = 3'd4;

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		unique case (step)
			STEP_WAIT:  w = '{op: OP_WAIT,  jmp: JMP_NO_START, target: STEP_WAIT,  last: 1'b0};
			STEP_DIV:   w = '{op: OP_DIV,   jmp: JMP_DIV_BUSY, target: STEP_DIV,   last: 1'b0};
			STEP_MUL:   w = '{op: OP_MUL,   jmp: JMP_NEVER,    target: STEP_WAIT,  last: 1'b0};
			STEP_SCALE: w = '{op: OP_SCALE, jmp: JMP_NEVER,    target: STEP_WAIT,  last: 1'b0};
			STEP_CLASS: w = '{op: OP_CLASS, jmp: JMP_OUT_BUSY, target: STEP_CLASS, last: 1'b1};
			default:    w = '{op: OP_WAIT,  jmp: JMP_NEVER,    target: STEP_WAIT,  last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

### rtl/core/bvm_in_if.sv
// ---------------------------------------------------------------------------
// bvm_in_if - tick channel
// One request per timer tick, carrying the latest ADC code.
// ---------------------------------------------------------------------------
interface bvm_in_if;
	logic                          valid;
	logic                          ready;
	logic [bvm_pkg::SAMPLE_W-1:0]  adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

### rtl/core/bvm_out_if.sv
// ---------------------------------------------------------------------------
// bvm_out_if - measurement result channel
// One request per measurement: average, voltage, status and discharge state.
// ---------------------------------------------------------------------------
interface bvm_out_if;
	logic                          valid;
	logic                          ready;
	logic [bvm_pkg::AVG_W-1:0]     average_code;
	logic [bvm_pkg::MV_W-1:0]      voltage_mv;
	logic [bvm_pkg::STATUS_W-1:0]  battery_status;
	logic [bvm_pkg::COUNT_W-1:0]   critical_count;
	logic                          discharge_flag;

	modport source (output valid, output average_code, output voltage_mv,
		output battery_status, output critical_count, output discharge_flag,
		input ready);
	modport sink   (input valid, input average_code, input voltage_mv,
		input battery_status, input critical_count, input discharge_flag,
		output ready);
endinterface

### rtl/core/bvm_sequencer.sv
// ---------------------------------------------------------------------------
// bvm_sequencer - microcode step counter
// Reads the control word of the current step and picks the next step.
// ---------------------------------------------------------------------------
module bvm_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  bvm_pkg::cond_t   cond,
	output bvm_pkg::ctrl_t   ctrl
);

	bvm_pkg::step_t step_q;
	bvm_pkg::step_t step_next;
	logic           taken;

	assign ctrl = bvm_pkg::ucode(step_q);

	always_comb begin
		unique case (ctrl.jmp)
			bvm_pkg::JMP_NO_START: taken = !cond.start;
			bvm_pkg::JMP_DIV_BUSY: taken = cond.div_busy;
			bvm_pkg::JMP_OUT_BUSY: taken = cond.out_busy;
			default:               taken = 1'b0;
		endcase
		if (taken) begin
			step_next = ctrl.target;
		end else if (ctrl.last) begin
			step_next = bvm_pkg::STEP_WAIT;
		end else begin
			step_next = step_q + bvm_pkg::step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bvm_pkg::STEP_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

### rtl/core/battery_voltage_monitor_top.sv
// ---------------------------------------------------------------------------
// battery_voltage_monitor_top - battery voltage monitor with moving average
// Counts ticks, averages the ADC code, scales to mV and classifies.
// ---------------------------------------------------------------------------
// A tick that does not measure is taken in the wait step and gives no result.
// A measuring tick (every measure_interval-th) runs the microcode program:
// a step to take it, the divider of the running average (two quotient
// bits a cycle), the vref multiply, a step to scale and one to classify;
// the next tick is taken in the cycle after classify. The result sits in an
// output register, so further ticks are taken while it waits; a second
// measurement stalls in its last step until the first is collected.
// Configuration writes are taken at any time and should be made while idle.
module battery_voltage_monitor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bvm_pkg::CFG_DATA_W-1:0] cfg_data,
	bvm_in_if.sink                         sample_ch,
	bvm_out_if.source                      result_ch
);

	// configuration
	logic [bvm_pkg::INTERVAL_W-1:0] interval_q;
	logic [bvm_pkg::WEIGHT_W-1:0]   weight_q;
	logic [bvm_pkg::VREF_W-1:0]     vref_q;
	logic [bvm_pkg::MV_W-1:0]       low_q;
	logic [bvm_pkg::MV_W-1:0]       crit_q;
	logic [bvm_pkg::MV_W-1:0]       absent_q;
	logic [bvm_pkg::COUNT_W-1:0]    limit_q;

	// state
	logic [bvm_pkg::INTERVAL_W-1:0] tick_q;
	logic [bvm_pkg::AVG_W-1:0]      avg_q;
	logic [bvm_pkg::COUNT_W-1:0]    crit_cnt_q;
	logic                           disch_q;

	// datapath
	logic [bvm_pkg::NUM_W-1:0]      num_q;
	logic [bvm_pkg::WEIGHT_W-1:0]   rem_q;
	logic [bvm_pkg::DVSR_W-1:0]     dvsr_q;
	logic [bvm_pkg::ITER_W-1:0]     iter_q;
	logic [bvm_pkg::PROD_W-1:0]     prod_q;
	logic [bvm_pkg::MV_W-1:0]       mv_q;

	// result register
	logic                           out_valid_q;
	logic [bvm_pkg::AVG_W-1:0]      out_avg_q;
	logic [bvm_pkg::MV_W-1:0]       out_mv_q;
	bvm_pkg::bat_status_t           out_status_q;
	logic [bvm_pkg::COUNT_W-1:0]    out_cnt_q;
	logic                           out_disch_q;

	bvm_pkg::ctrl_t ctrl;
	bvm_pkg::cond_t cond;

	logic                           accept;
	logic [bvm_pkg::INTERVAL_W-1:0] tick_inc;
	logic [bvm_pkg::INTERVAL_W-1:0] interval_eff;
	logic                           measure;
	logic [bvm_pkg::AVG_W-1:0]      sample_m;
	logic [bvm_pkg::NUM_W-1:0]      num_load;

	logic [bvm_pkg::DVSR_W-1:0]     r1, r2;
	logic [bvm_pkg::DVSR_W-1:0]     r1s, r2s;
	logic                           q1, q2;

	logic [bvm_pkg::AVG_W-1:0]      quot;
	logic [bvm_pkg::PROD_W-1:0]     mv_raw;

	logic                           out_take;
	logic                           load_out;
	logic [bvm_pkg::COUNT_W-1:0]    cnt_next;
	logic                           disch_next;
	bvm_pkg::bat_status_t           status_next;

	bvm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	assign sample_ch.ready = (ctrl.op == bvm_pkg::OP_WAIT);
	assign accept          = sample_ch.valid && sample_ch.ready;

	assign tick_inc     = tick_q + bvm_pkg::INTERVAL_W'(1);
	assign interval_eff = (interval_q == '0) ? bvm_pkg::INTERVAL_W'(1) : interval_q;
	assign measure      = (tick_inc >= interval_eff);

	assign sample_m = sample_ch.adc_sample & bvm_pkg::AMASK;
	assign num_load = bvm_pkg::NUM_W'(avg_q) * bvm_pkg::NUM_W'(weight_q)
	                + bvm_pkg::NUM_W'(sample_m);

	// restoring division, two bits a cycle; remainder stays below the divisor
	always_comb begin
		r1  = {rem_q, num_q[bvm_pkg::NUM_W-1]};
		q1  = (r1 >= dvsr_q);
		r1s = q1 ? (r1 - dvsr_q) : r1;
		r2  = {r1s[bvm_pkg::WEIGHT_W-1:0], num_q[bvm_pkg::NUM_W-2]};
		q2  = (r2 >= dvsr_q);
		r2s = q2 ? (r2 - dvsr_q) : r2;
	end

	assign quot   = num_q[bvm_pkg::AVG_W-1:0] & bvm_pkg::AMASK;
	assign mv_raw = prod_q >> bvm_pkg::ADC_BITS;

	assign out_take = out_valid_q && result_ch.ready;

	assign cond.start    = accept && measure;
	assign cond.div_busy = (iter_q != bvm_pkg::ITER_W'(bvm_pkg::DIV_STEPS - 1));
	assign cond.out_busy = out_valid_q && !result_ch.ready;

	assign load_out = (ctrl.op == bvm_pkg::OP_CLASS) && !cond.out_busy;

	always_comb begin
		cnt_next = crit_cnt_q;
		if ((mv_q <= crit_q) && (crit_cnt_q != '1)) begin
			cnt_next = crit_cnt_q + bvm_pkg::COUNT_W'(1);
		end
		disch_next = disch_q || (cnt_next >= limit_q);
		priority if ((mv_q <= low_q) && (mv_q > crit_q)) begin
			status_next = bvm_pkg::BAT_LOW;
		end else if (disch_next) begin
			status_next = bvm_pkg::BAT_DISCHARGED;
		end else if (mv_q < absent_q) begin
			status_next = bvm_pkg::BAT_ABSENT;
		end else begin
			status_next = bvm_pkg::BAT_NORMAL;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= bvm_pkg::RST_INTERVAL;
			weight_q   <= bvm_pkg::RST_WEIGHT;
			vref_q     <= bvm_pkg::RST_VREF;
			low_q      <= bvm_pkg::RST_LOW;
			crit_q     <= bvm_pkg::RST_CRIT;
			absent_q   <= bvm_pkg::RST_ABSENT;
			limit_q    <= bvm_pkg::RST_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bvm_pkg::REG_INTERVAL: interval_q <= cfg_data[bvm_pkg::INTERVAL_W-1:0];
				bvm_pkg::REG_WEIGHT:   weight_q   <= cfg_data[bvm_pkg::WEIGHT_W-1:0];
				bvm_pkg::REG_VREF:     vref_q     <= cfg_data[bvm_pkg::VREF_W-1:0];
				bvm_pkg::REG_LOW:      low_q      <= cfg_data[bvm_pkg::MV_W-1:0];
				bvm_pkg::REG_CRIT:     crit_q     <= cfg_data[bvm_pkg::MV_W-1:0];
				bvm_pkg::REG_ABSENT:   absent_q   <= cfg_data[bvm_pkg::MV_W-1:0];
				bvm_pkg::REG_LIMIT:    limit_q    <= cfg_data[bvm_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			avg_q      <= bvm_pkg::RST_AVG;
			crit_cnt_q <= '0;
			disch_q    <= 1'b0;
		end else begin
			if (accept) begin
				tick_q <= measure ? '0 : tick_inc;
			end
			if (ctrl.op == bvm_pkg::OP_MUL) begin
				avg_q <= quot;
			end
			if (load_out) begin
				crit_cnt_q <= cnt_next;
				disch_q    <= disch_next;
			end
		end
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cond.start) begin
			iter_q <= '0;
		end else if (ctrl.op == bvm_pkg::OP_DIV) begin
			iter_q <= iter_q + bvm_pkg::ITER_W'(1);
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (cond.start) begin
			num_q  <= num_load;
			rem_q  <= '0;
			dvsr_q <= bvm_pkg::DVSR_W'(weight_q) + bvm_pkg::DVSR_W'(1);
		end else if (ctrl.op == bvm_pkg::OP_DIV) begin
			num_q <= {num_q[bvm_pkg::NUM_W-3:0], q1, q2};
			rem_q <= r2s[bvm_pkg::WEIGHT_W-1:0];
		end
		if (ctrl.op == bvm_pkg::OP_MUL) begin
			prod_q <= {bvm_pkg::PROD_W'(vref_q) * bvm_pkg::PROD_W'(quot)}
				<< 1;
		end
		if (ctrl.op == bvm_pkg::OP_SCALE) begin
			mv_q <= (mv_raw > bvm_pkg::PROD_W'(bvm_pkg::MV_MAX)) ?
				bvm_pkg::MV_MAX : mv_raw[bvm_pkg::MV_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_avg_q    <= avg_q;
			out_mv_q     <= mv_q;
			out_status_q <= status_next;
			out_cnt_q    <= cnt_next;
			out_disch_q  <= disch_next;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.average_code   = out_avg_q;
	assign result_ch.voltage_mv     = out_mv_q;
	assign result_ch.battery_status = out_status_q;
	assign result_ch.critical_count = out_cnt_q;
	assign result_ch.discharge_flag = out_disch_q;

endmodule
